[src/hldq_pkg.sv]
// Shared operation codes and control/status structs for the hop-bounded label distance query.
`default_nettype none

package hldq_pkg;

	// Width of the operation selector carried on the input tuser.
	localparam int unsigned OP_W = 2;

	// Operation codes of an input word.
	localparam logic [OP_W-1:0] OP_LOAD_FIRST  = 2'd0;
	localparam logic [OP_W-1:0] OP_LOAD_SECOND = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY       = 2'd2;

	// Control from the top level to the scan engine.
	typedef struct packed {
		logic start;  // query word accepted this cycle
		logic ack;    // result taken into the output register
	} scan_ctl_t;

	// Status from the scan engine to the top level.
	typedef struct packed {
		logic busy;   // a query is being scanned or its result waits
		logic done;   // result fields are final
	} scan_stat_t;

endpackage

`default_nettype wire

[src/hldq_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module hldq_ram #(
	parameter int unsigned WIDTH = 60,
	parameter int unsigned DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

[src/hldq_scan.sv]
// Query scan engine: walks both label stores and keeps the best qualifying hub pair.
`default_nettype none

module hldq_scan
	import hldq_pkg::*;
#(
	parameter int unsigned LABEL_DEPTH = 256,
	parameter int unsigned HUB_BITS    = 20,
	parameter int unsigned HOP_BITS    = 8,
	parameter int unsigned DIST_BITS   = 32
) (
	input  wire logic                                        clk,
	input  wire logic                                        arst_n,
	input  wire scan_ctl_t                                   ctl,
	input  wire logic [HOP_BITS:0]                           limit,
	input  wire logic [$clog2(LABEL_DEPTH+1)-1:0]            first_count,
	input  wire logic [$clog2(LABEL_DEPTH+1)-1:0]            second_count,
	output logic      [$clog2(LABEL_DEPTH)-1:0]              first_raddr,
	input  wire logic [HUB_BITS+HOP_BITS+DIST_BITS-1:0]      first_rdata,
	output logic      [$clog2(LABEL_DEPTH)-1:0]              second_raddr,
	input  wire logic [HUB_BITS+HOP_BITS+DIST_BITS-1:0]      second_rdata,
	output scan_stat_t                                       stat,
	output logic                                             found,
	output logic      [DIST_BITS:0]                          total_distance,
	output logic      [HUB_BITS-1:0]                         best_hub,
	output logic      [HOP_BITS-1:0]                         first_hops,
	output logic      [HOP_BITS-1:0]                         second_hops
);

	localparam int unsigned AW    = $clog2(LABEL_DEPTH);
	localparam int unsigned CNT_W = $clog2(LABEL_DEPTH + 1);
	localparam int unsigned LIM_W = HOP_BITS + 1;
	localparam int unsigned SUM_W = DIST_BITS + 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FETCH,
		S_WAIT,
		S_RANK,
		S_PAIR,
		S_DONE
	} state_t;

	state_t state_q;

	logic [LIM_W-1:0]     lim_q;
	logic [CNT_W-1:0]     nf_q;
	logic [CNT_W-1:0]     ns_q;
	logic [CNT_W-1:0]     i_q;
	logic [CNT_W-1:0]     k_q;
	logic [CNT_W-1:0]     j_q;
	logic                 rv_s1;
	logic [AW-1:0]        k_s1;
	logic                 pv_s1;
	logic [HUB_BITS-1:0]  a_hub_q;
	logic [HOP_BITS-1:0]  a_hops_q;
	logic [DIST_BITS-1:0] a_dist_q;
	logic [AW-1:0]        rank_q;
	logic                 have_q;
	logic [SUM_W-1:0]     best_sum_q;
	logic [AW-1:0]        best_rank_q;
	logic [HUB_BITS-1:0]  best_hub_q;
	logic [HOP_BITS-1:0]  best_hf_q;
	logic [HOP_BITS-1:0]  best_hs_q;

	logic [HUB_BITS-1:0]  f_hub;
	logic [HOP_BITS-1:0]  f_hops;
	logic [DIST_BITS-1:0] f_dist;
	logic [HUB_BITS-1:0]  s_hub;
	logic [HOP_BITS-1:0]  s_hops;
	logic [DIST_BITS-1:0] s_dist;
	logic                 rank_issue;
	logic                 pair_issue;
	logic                 rank_hit;
	logic                 cand;
	logic [SUM_W-1:0]     sum;
	logic                 better;
	logic                 last_i;

	// Entry layout: distance in the low bits, then hops, then hub.
	assign f_dist = first_rdata[DIST_BITS-1:0];
	assign f_hops = first_rdata[DIST_BITS+HOP_BITS-1:DIST_BITS];
	assign f_hub  = first_rdata[DIST_BITS+HOP_BITS+HUB_BITS-1:DIST_BITS+HOP_BITS];
	assign s_dist = second_rdata[DIST_BITS-1:0];
	assign s_hops = second_rdata[DIST_BITS+HOP_BITS-1:DIST_BITS];
	assign s_hub  = second_rdata[DIST_BITS+HOP_BITS+HUB_BITS-1:DIST_BITS+HOP_BITS];

	// Read issue: one address per cycle, data compared in the next cycle.
	assign rank_issue   = (state_q == S_RANK) && (k_q <= i_q);
	assign pair_issue   = (state_q == S_PAIR) && (j_q < ns_q);
	assign first_raddr  = (state_q == S_FETCH) ? i_q[AW-1:0] : k_q[AW-1:0];
	assign second_raddr = j_q[AW-1:0];

	// The hub's rank is the first entry at or before i that has the same hub and fits the limit.
	assign rank_hit = rv_s1 && ({1'b0, f_hops} <= lim_q) && (f_hub == a_hub_q);

	// Pair check and ordering: sum, then hub rank, then first hops; scan order settles the rest.
	assign cand   = pv_s1 && (s_hub == a_hub_q)
	                && ((LIM_W'(a_hops_q) + LIM_W'(s_hops)) <= lim_q);
	assign sum    = SUM_W'(a_dist_q) + SUM_W'(s_dist);
	assign better = !have_q || (sum < best_sum_q)
	                || ((sum == best_sum_q)
	                    && ((rank_q < best_rank_q)
	                        || ((rank_q == best_rank_q) && (a_hops_q < best_hf_q))));
	assign last_i = ((i_q + CNT_W'(1)) == nf_q);

	// Sequencer with its registered result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rv_s1   <= 1'b0;
			pv_s1   <= 1'b0;
			have_q  <= 1'b0;
		end else begin
			// A rank hit ends the rank walk, so a read issued alongside it is dropped.
			rv_s1 <= rank_issue && !rank_hit;
			pv_s1 <= pair_issue;
			if (rank_issue) begin
				k_q  <= k_q + CNT_W'(1);
				k_s1 <= k_q[AW-1:0];
			end
			if (pair_issue) begin
				j_q <= j_q + CNT_W'(1);
			end
			unique case (state_q)
				S_IDLE: begin
					if (ctl.start) begin
						lim_q       <= limit;
						nf_q        <= first_count;
						ns_q        <= second_count;
						i_q         <= '0;
						have_q      <= 1'b0;
						best_sum_q  <= '0;
						best_rank_q <= '0;
						best_hub_q  <= '0;
						best_hf_q   <= '0;
						best_hs_q   <= '0;
						state_q     <= (first_count == '0) ? S_DONE : S_FETCH;
					end
				end
				S_FETCH: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					a_hub_q  <= f_hub;
					a_hops_q <= f_hops;
					a_dist_q <= f_dist;
					// A first entry over the limit takes no part at all.
					if ({1'b0, f_hops} > lim_q) begin
						if (last_i) begin
							state_q <= S_DONE;
						end else begin
							i_q     <= i_q + CNT_W'(1);
							state_q <= S_FETCH;
						end
					end else begin
						k_q     <= '0;
						state_q <= S_RANK;
					end
				end
				S_RANK: begin
					if (rank_hit) begin
						rank_q  <= k_s1;
						j_q     <= '0;
						state_q <= S_PAIR;
					end
				end
				S_PAIR: begin
					if (cand && better) begin
						have_q      <= 1'b1;
						best_sum_q  <= sum;
						best_rank_q <= rank_q;
						best_hub_q  <= a_hub_q;
						best_hf_q   <= a_hops_q;
						best_hs_q   <= s_hops;
					end
					if ((j_q == ns_q) && !pv_s1) begin
						if (last_i) begin
							state_q <= S_DONE;
						end else begin
							i_q     <= i_q + CNT_W'(1);
							state_q <= S_FETCH;
						end
					end
				end
				S_DONE: begin
					if (ctl.ack) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign stat.busy      = (state_q != S_IDLE);
	assign stat.done      = (state_q == S_DONE);
	assign found          = have_q;
	assign total_distance = best_sum_q;
	assign best_hub       = best_hub_q;
	assign first_hops     = best_hf_q;
	assign second_hops    = best_hs_q;

endmodule

`default_nettype wire

[src/hop_bounded_label_distance_query_core.sv]
// Top level of the hop-bounded label distance query: label loading, stores and result register.
//
//  channel  | dir | word contents
//  s_axis   | in  | tuser: operation; tdata: hub, hops, distance, hop_limit
//  m_axis   | out | tuser: found; tdata: total_distance, best_hub, first_hops,
//           |     |        second_hops, overflowed
//
// Label words load at one word per cycle while no query is in flight.
// A query visits each first entry in turn: it fetches the entry, skips it when over the
// limit, else walks the first store toward it for the hub's rank, then every second entry;
// the single read port of each label memory, one entry read per cycle, sets the query time.
// The input stalls during the scan; the result register is a separate stage, so
// loads continue while a result waits. Reset empties both stores at once through
// their fill counts.
`default_nettype none

module hop_bounded_label_distance_query_core
	import hldq_pkg::*;
#(
	parameter int unsigned LABEL_DEPTH = 256,
	parameter int unsigned HUB_BITS    = 20,
	parameter int unsigned HOP_BITS    = 8,
	parameter int unsigned DIST_BITS   = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_axis_tvalid,
	output logic      s_axis_tready,
	// tdata from bit 0: hub, hops, distance, hop_limit, zero fill
	input  wire logic [((HUB_BITS+2*HOP_BITS+DIST_BITS+1+7)/8)*8-1:0] s_axis_tdata,
	// tuser: operation
	input  wire logic [OP_W-1:0] s_axis_tuser,
	output logic      m_axis_tvalid,
	input  wire logic m_axis_tready,
	// tdata from bit 0: total_distance, best_hub, first_hops, second_hops, overflowed, zero fill
	output logic [((DIST_BITS+1+HUB_BITS+2*HOP_BITS+1+7)/8)*8-1:0] m_axis_tdata,
	// tuser: found
	output logic [0:0] m_axis_tuser
);

	localparam int unsigned AW     = $clog2(LABEL_DEPTH);
	localparam int unsigned CNT_W  = $clog2(LABEL_DEPTH + 1);
	localparam int unsigned ENT_W  = HUB_BITS + HOP_BITS + DIST_BITS;
	localparam int unsigned HOPS_O = HUB_BITS;
	localparam int unsigned DIST_O = HUB_BITS + HOP_BITS;
	localparam int unsigned LIM_O  = HUB_BITS + HOP_BITS + DIST_BITS;
	localparam int unsigned OUT_W  = DIST_BITS + 1 + HUB_BITS + 2 * HOP_BITS + 1;
	localparam int unsigned OUT_TW = ((OUT_W + 7) / 8) * 8;

	logic [HUB_BITS-1:0]  in_hub;
	logic [HOP_BITS-1:0]  in_hops;
	logic [DIST_BITS-1:0] in_dist;
	logic [HOP_BITS:0]    in_limit;
	logic [ENT_W-1:0]     in_entry;
	logic                 in_acc;
	logic                 load_first;
	logic                 load_second;
	logic                 first_full;
	logic                 second_full;

	logic [CNT_W-1:0]     first_cnt_q;
	logic [CNT_W-1:0]     second_cnt_q;
	logic                 overflow_q;

	scan_ctl_t            ctl;
	scan_stat_t           stat;
	logic [AW-1:0]        first_raddr;
	logic [AW-1:0]        second_raddr;
	logic [ENT_W-1:0]     first_rdata;
	logic [ENT_W-1:0]     second_rdata;
	logic                 found;
	logic [DIST_BITS:0]   total_distance;
	logic [HUB_BITS-1:0]  best_hub;
	logic [HOP_BITS-1:0]  first_hops;
	logic [HOP_BITS-1:0]  second_hops;

	logic                 m_valid_q;
	logic [OUT_W-1:0]     m_data_q;
	logic                 m_found_q;

	// Unpack the input word.
	assign in_hub   = s_axis_tdata[HUB_BITS-1:0];
	assign in_hops  = s_axis_tdata[HOPS_O+HOP_BITS-1:HOPS_O];
	assign in_dist  = s_axis_tdata[DIST_O+DIST_BITS-1:DIST_O];
	assign in_limit = s_axis_tdata[LIM_O+HOP_BITS:LIM_O];
	assign in_entry = {in_hub, in_hops, in_dist};

	// Inputs are taken whenever no query is in flight.
	assign s_axis_tready = !stat.busy;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign first_full    = (first_cnt_q == CNT_W'(LABEL_DEPTH));
	assign second_full   = (second_cnt_q == CNT_W'(LABEL_DEPTH));
	assign load_first    = in_acc && (s_axis_tuser == OP_LOAD_FIRST) && !first_full;
	assign load_second   = in_acc && (s_axis_tuser == OP_LOAD_SECOND) && !second_full;

	assign ctl.start = in_acc && (s_axis_tuser == OP_QUERY);
	assign ctl.ack   = stat.done && (!m_valid_q || m_axis_tready);

	// Fill counts and the drop flag; a finished query empties both stores.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_cnt_q  <= '0;
			second_cnt_q <= '0;
			overflow_q   <= 1'b0;
		end else if (ctl.ack) begin
			first_cnt_q  <= '0;
			second_cnt_q <= '0;
			overflow_q   <= 1'b0;
		end else begin
			if (load_first) begin
				first_cnt_q <= first_cnt_q + CNT_W'(1);
			end
			if (load_second) begin
				second_cnt_q <= second_cnt_q + CNT_W'(1);
			end
			if (in_acc && (((s_axis_tuser == OP_LOAD_FIRST) && first_full)
			               || ((s_axis_tuser == OP_LOAD_SECOND) && second_full))) begin
				overflow_q <= 1'b1;
			end
		end
	end

	// Label stores.
	hldq_ram #(
		.WIDTH (ENT_W),
		.DEPTH (LABEL_DEPTH)
	) u_first_store (
		.clk   (clk),
		.we    (load_first),
		.waddr (first_cnt_q[AW-1:0]),
		.wdata (in_entry),
		.raddr (first_raddr),
		.rdata (first_rdata)
	);

	hldq_ram #(
		.WIDTH (ENT_W),
		.DEPTH (LABEL_DEPTH)
	) u_second_store (
		.clk   (clk),
		.we    (load_second),
		.waddr (second_cnt_q[AW-1:0]),
		.wdata (in_entry),
		.raddr (second_raddr),
		.rdata (second_rdata)
	);

	hldq_scan #(
		.LABEL_DEPTH (LABEL_DEPTH),
		.HUB_BITS    (HUB_BITS),
		.HOP_BITS    (HOP_BITS),
		.DIST_BITS   (DIST_BITS)
	) u_scan (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.limit          (in_limit),
		.first_count    (first_cnt_q),
		.second_count   (second_cnt_q),
		.first_raddr    (first_raddr),
		.first_rdata    (first_rdata),
		.second_raddr   (second_raddr),
		.second_rdata   (second_rdata),
		.stat           (stat),
		.found          (found),
		.total_distance (total_distance),
		.best_hub       (best_hub),
		.first_hops     (first_hops),
		.second_hops    (second_hops)
	);

	// Output register: holds a result until the downstream side takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (ctl.ack) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ack) begin
			m_data_q  <= {overflow_q, second_hops, first_hops, best_hub, total_distance};
			m_found_q <= found;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = OUT_TW'(m_data_q);
	assign m_axis_tuser  = m_found_q;

endmodule

`default_nettype wire

[src/hldq_checker.sv]
// Port-level checker for the hop-bounded label distance query core, with its bind.
`default_nettype none

module hldq_checker
	import hldq_pkg::*;
#(
	parameter int unsigned HUB_BITS  = 20,
	parameter int unsigned HOP_BITS  = 8,
	parameter int unsigned DIST_BITS = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	input wire logic s_axis_tready,
	input wire logic [OP_W-1:0] s_axis_tuser,
	input wire logic m_axis_tvalid,
	input wire logic m_axis_tready,
	input wire logic [((DIST_BITS+1+HUB_BITS+2*HOP_BITS+1+7)/8)*8-1:0] m_axis_tdata,
	input wire logic [0:0] m_axis_tuser
);

	localparam int unsigned RES_W = DIST_BITS + 1 + HUB_BITS + 2 * HOP_BITS;

	logic query_acc;
	logic result_acc;
	logic [1:0] pend_q;

	assign query_acc  = s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_QUERY);
	assign result_acc = m_axis_tvalid && m_axis_tready;

	// Queries accepted whose results have not yet been taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (query_acc && !result_acc) begin
			pend_q <= pend_q + 2'd1;
		end else if (!query_acc && result_acc) begin
			pend_q <= pend_q - 2'd1;
		end
	end

	// A stalled result word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser))
		else $error("result word changed while stalled");

	// The input closes for the scan after a query is taken.
	a_query_stall: assert property (@(posedge clk) disable iff (!arst_n)
		query_acc |=> !s_axis_tready)
		else $error("input open right after a query");

	// A result appears only for a query.
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> pend_q != 2'd0)
		else $error("result without a pending query");

	// No more than one scanning query plus one waiting result.
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("too many queries in flight");

	// Without a qualifying pair every result field reads zero.
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[RES_W-1:0] == '0)
		else $error("nonzero result fields with found low");

endmodule

bind hop_bounded_label_distance_query_core hldq_checker #(
	.HUB_BITS  (HUB_BITS),
	.HOP_BITS  (HOP_BITS),
	.DIST_BITS (DIST_BITS)
) u_hldq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

[test/hop_bounded_label_distance_query_core_test.sv]
// Self-checking testbench for the hop-bounded label distance query core.
module hop_bounded_label_distance_query_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import hldq_pkg::*;

	localparam int IN_W  = 72;
	localparam int OUT_W = 72;

	// The operation selector has one value the block must ignore.
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	// One expected query answer, in the field widths of the block.
	typedef struct packed {
		logic        found;
		logic [32:0] total;
		logic [19:0] hub;
		logic [7:0]  first_hops;
		logic [7:0]  second_hops;
		logic        overflowed;
	} answer_t;

	// Keeps its own copy of both label stores and predicts every query answer.
	class label_query_scoreboard;
		localparam int STORE_DEPTH = 256;

		typedef struct {
			logic [19:0] hub;
			logic [7:0]  hops;
			logic [31:0] distance;
		} entry_t;

		entry_t      first_label[$];
		entry_t      second_label[$];
		bit          dropped;
		answer_t     pending_answers[$];
		int unsigned errors;
		int unsigned queries_noted;
		int unsigned answers_seen;

		task report_mismatch(string what);
			errors++;
			$display("[%0t] mismatch: %s", $time, what);
		endtask

		function entry_t entry_of(logic [IN_W-1:0] data);
			entry_t e;
			e.hub      = data[19:0];
			e.hops     = data[27:20];
			e.distance = data[59:28];
			return e;
		endfunction

		// Least distance sum over same-hub pairs within the hop limit, then clear both stores.
		function void predict_query(logic [8:0] limit);
			answer_t ans;
			int      rank [STORE_DEPTH];
			int      best_rank;
			int      i;
			int      j;
			int      k;
			bit      have;
			bit      better;
			logic [32:0] sum;
			ans = '0;
			have = 1'b0;
			best_rank = 0;
			// A hub ranks by its first entry that fits the limit.
			for (i = 0; i < first_label.size(); i++) begin
				rank[i] = i;
				for (k = 0; k < i; k++) begin
					if (first_label[k].hops <= limit && first_label[k].hub == first_label[i].hub) begin
						rank[i] = k;
						break;
					end
				end
			end
			// Scan in (first, second) order; strict compares keep the earliest pair.
			for (i = 0; i < first_label.size(); i++) begin
				if (first_label[i].hops > limit)
					continue;
				for (j = 0; j < second_label.size(); j++) begin
					if (second_label[j].hub != first_label[i].hub)
						continue;
					if ({1'b0, first_label[i].hops} + {1'b0, second_label[j].hops} > limit)
						continue;
					sum = {1'b0, first_label[i].distance} + {1'b0, second_label[j].distance};
					if (!have)
						better = 1'b1;
					else if (sum != ans.total)
						better = sum < ans.total;
					else if (rank[i] != best_rank)
						better = rank[i] < best_rank;
					else
						better = first_label[i].hops < ans.first_hops;
					if (better) begin
						have = 1'b1;
						best_rank = rank[i];
						ans.total = sum;
						ans.hub = first_label[i].hub;
						ans.first_hops = first_label[i].hops;
						ans.second_hops = second_label[j].hops;
					end
				end
			end
			ans.found = have;
			ans.overflowed = dropped;
			pending_answers.insert(pending_answers.size(), ans);
			first_label.delete();
			second_label.delete();
			dropped = 1'b0;
			queries_noted++;
		endfunction

		// Called for every word the block accepts.
		function void note_word(logic [OP_W-1:0] op, logic [IN_W-1:0] data);
			case (op)
				OP_LOAD_FIRST: begin
					if (first_label.size() >= STORE_DEPTH)
						dropped = 1'b1;
					else
						first_label.insert(first_label.size(), entry_of(data));
				end
				OP_LOAD_SECOND: begin
					if (second_label.size() >= STORE_DEPTH)
						dropped = 1'b1;
					else
						second_label.insert(second_label.size(), entry_of(data));
				end
				OP_QUERY: predict_query(data[68:60]);
				default: ;
			endcase
		endfunction

		task compare_field(string name, logic [32:0] got, logic [32:0] want);
			if (got !== want)
				report_mismatch($sformatf("answer %0d %s: got %0h, expected %0h",
					answers_seen, name, got, want));
		endtask

		// Called for every answer word the block delivers.
		task check_answer(logic found, logic [OUT_W-1:0] data);
			answer_t want;
			if (pending_answers.size() == 0) begin
				report_mismatch($sformatf("unexpected answer word %0h found %0b", data, found));
				return;
			end
			want = pending_answers.pop_front();
			compare_field("found", found, want.found);
			compare_field("total_distance", data[32:0], want.total);
			compare_field("best_hub", data[52:33], want.hub);
			compare_field("first_hops", data[60:53], want.first_hops);
			compare_field("second_hops", data[68:61], want.second_hops);
			compare_field("overflowed", data[69], want.overflowed);
			answers_seen++;
		endtask
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_axis_tvalid;
	logic             s_axis_tready;
	logic [IN_W-1:0]  s_axis_tdata;
	logic [OP_W-1:0]  s_axis_tuser;
	logic             m_axis_tvalid;
	logic             m_axis_tready;
	logic [OUT_W-1:0] m_axis_tdata;
	logic [0:0]       m_axis_tuser;

	label_query_scoreboard sb;
	bit gaps_on = 1'b1;
	int hold_ticket = 0;
	int send_calm = 0;
	int words_sent = 0;

	hop_bounded_label_distance_query_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	always #5 clk = ~clk;

	// Offer one word, with an occasional idle burst ahead of it, and wait for acceptance.
	task automatic send_word(input logic [OP_W-1:0] op, input logic [19:0] hub,
		input logic [7:0] hops, input logic [31:0] distance, input logic [8:0] limit);
		if (gaps_on) begin
			if (send_calm > 0) begin
				send_calm--;
			end else begin
				case ($urandom_range(0, 9))
					0, 1: begin
						s_axis_tvalid <= 1'b0;
						repeat ($urandom_range(1, 16)) @(posedge clk);
					end
					2: send_calm = $urandom_range(10, 60);
					default: ;
				endcase
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {3'b000, limit, distance, hops, hub};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_word(op, {3'b000, limit, distance, hops, hub});
		if (op != OP_UNUSED)
			words_sent++;
	endtask

	// Mostly small distances so that ties happen, with full-range and top values mixed in.
	function automatic logic [31:0] random_distance();
		case ($urandom_range(0, 4))
			3: return $urandom;
			4: return 32'hFFFF_FFFF - $urandom_range(0, 3);
			default: return $urandom_range(0, 15);
		endcase
	endfunction

	// Load nf first and ns second entries drawn from a small hub pool, then query.
	// A negative fixed_limit picks the hop limit at random.
	task automatic run_set(input int nf, input int ns, input int fixed_limit);
		logic [19:0] pool [4];
		int          last_first [4];
		int          last_second [4];
		int          hop_base;
		int          left_first;
		int          left_second;
		int          p;
		int          h;
		int          limit;
		bit          sparse;
		bit          noisy;
		logic [OP_W-1:0] op;
		hop_base = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 250) : 0;
		sparse = ($urandom_range(0, 7) == 0);
		noisy = ($urandom_range(0, 3) == 0);
		for (p = 0; p < 4; p++) begin
			pool[p] = 20'($urandom_range(0, 20'hFFFFF));
			last_first[p] = hop_base;
			last_second[p] = hop_base;
		end
		left_first = nf;
		left_second = ns;
		while (left_first + left_second > 0) begin
			if (left_second == 0 || (left_first > 0 && $urandom_range(0, 1) == 1)) begin
				op = OP_LOAD_FIRST;
				left_first--;
			end else begin
				op = OP_LOAD_SECOND;
				left_second--;
			end
			p = $urandom_range(0, 3);
			// Hops ascend per hub as labels are built, with some words out of order.
			if ($urandom_range(0, 3) == 0) begin
				h = $urandom_range(0, 255);
			end else if (op == OP_LOAD_FIRST) begin
				h = last_first[p] + $urandom_range(0, 2);
				if (h > 255)
					h = 255;
				last_first[p] = h;
			end else begin
				h = last_second[p] + $urandom_range(0, 2);
				if (h > 255)
					h = 255;
				last_second[p] = h;
			end
			send_word(op, sparse ? 20'($urandom_range(0, 20'hFFFFF)) : pool[p], 8'(h),
				random_distance(), 9'($urandom_range(0, 511)));
			if (noisy && $urandom_range(0, 5) == 0)
				send_word(OP_UNUSED, 20'($urandom_range(0, 20'hFFFFF)),
					8'($urandom_range(0, 255)), $urandom, 9'($urandom_range(0, 511)));
		end
		if (fixed_limit >= 0) begin
			limit = fixed_limit;
		end else if ($urandom_range(0, 9) < 7) begin
			limit = 2 * hop_base + $urandom_range(0, 12);
			if (limit > 511)
				limit = 511;
		end else begin
			limit = $urandom_range(0, 511);
		end
		send_word(OP_QUERY, 20'($urandom_range(0, 20'hFFFFF)), 8'($urandom_range(0, 255)),
			$urandom, 9'(limit));
	endtask

	// Answer side: random stalls, calm stretches, and one long hold-off on request.
	initial begin : answer_sink
		int stall_left;
		int calm_left;
		int hold_taken;
		stall_left = 0;
		calm_left = 0;
		hold_taken = 0;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_answer(m_axis_tuser[0], m_axis_tdata);
			if (hold_ticket != hold_taken) begin
				hold_taken = hold_ticket;
				stall_left = 600;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else if (!gaps_on || calm_left > 0) begin
				if (calm_left > 0)
					calm_left--;
				m_axis_tready <= 1'b1;
			end else begin
				case ($urandom_range(0, 9))
					0, 1: begin
						stall_left = $urandom_range(0, 15);
						m_axis_tready <= 1'b0;
					end
					2: begin
						calm_left = $urandom_range(10, 80);
						m_axis_tready <= 1'b1;
					end
					default: m_axis_tready <= 1'b1;
				endcase
			end
		end
	end

	// Stimulus: directed cases, full stores, back-pressure, then random label sets.
	initial begin : stimulus
		int base_queries;
		sb = new();
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = OP_LOAD_FIRST;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Query on empty stores, then a word with the unused operation.
		send_word(OP_QUERY, 20'h0, 8'd0, 32'h0, 9'd0);
		send_word(OP_UNUSED, 20'hFFFFF, 8'hFF, 32'hFFFF_FFFF, 9'h1FF);
		// Largest fields: the pair fits the widest limit, then misses by one hop.
		send_word(OP_LOAD_FIRST, 20'hFFFFF, 8'hFF, 32'hFFFF_FFFF, 9'h0);
		send_word(OP_LOAD_SECOND, 20'hFFFFF, 8'hFF, 32'hFFFF_FFFF, 9'h0);
		send_word(OP_QUERY, 20'h0, 8'd0, 32'h0, 9'd511);
		send_word(OP_LOAD_FIRST, 20'hFFFFF, 8'hFF, 32'hFFFF_FFFF, 9'h0);
		send_word(OP_LOAD_SECOND, 20'hFFFFF, 8'hFF, 32'hFFFF_FFFF, 9'h0);
		send_word(OP_QUERY, 20'h0, 8'd0, 32'h0, 9'd509);
		// All-zero entries under a zero limit.
		send_word(OP_LOAD_FIRST, 20'h0, 8'd0, 32'h0, 9'h0);
		send_word(OP_LOAD_SECOND, 20'h0, 8'd0, 32'h0, 9'h0);
		send_word(OP_QUERY, 20'h0, 8'd0, 32'h0, 9'd0);
		// An entry over the limit does not set its hub's place in the tie order.
		send_word(OP_LOAD_FIRST, 20'd5, 8'd9, 32'd1, 9'h0);
		send_word(OP_LOAD_FIRST, 20'd6, 8'd1, 32'd4, 9'h0);
		send_word(OP_LOAD_FIRST, 20'd5, 8'd2, 32'd4, 9'h0);
		send_word(OP_LOAD_SECOND, 20'd5, 8'd0, 32'd6, 9'h0);
		send_word(OP_LOAD_SECOND, 20'd6, 8'd0, 32'd6, 9'h0);
		send_word(OP_QUERY, 20'h0, 8'd0, 32'h0, 9'd8);
		// Equal sums on one hub: the smaller first hop wins, then the earlier second entry.
		send_word(OP_LOAD_FIRST, 20'd9, 8'd3, 32'd5, 9'h0);
		send_word(OP_LOAD_FIRST, 20'd9, 8'd1, 32'd5, 9'h0);
		send_word(OP_LOAD_SECOND, 20'd9, 8'd2, 32'd3, 9'h0);
		send_word(OP_LOAD_SECOND, 20'd9, 8'd0, 32'd3, 9'h0);
		send_word(OP_QUERY, 20'h0, 8'd0, 32'h0, 9'd4);

		// Full stores drop further entries and flag it once.
		run_set(258, 2, -1);
		run_set(3, 260, -1);
		run_set(2, 2, -1);
		// Both stores full, every pair within the limit.
		run_set(256, 256, 511);

		// The answer side holds off while queries keep coming, so the input stalls.
		hold_ticket <= hold_ticket + 1;
		repeat (8) run_set(2, 2, -1);

		// Random label sets up to the word budget; the last stretch runs without idling.
		base_queries = sb.queries_noted;
		while (words_sent < 1250 || sb.queries_noted - base_queries < 10) begin
			if (words_sent >= 1200)
				gaps_on <= 1'b0;
			run_set($urandom_range(0, 10), $urandom_range(0, 10), -1);
		end
		s_axis_tvalid <= 1'b0;

		while (sb.pending_answers.size() != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);
		if (sb.errors == 0)
			$display("hop_bounded_label_distance_query_core regression: pass");
		else
			$display("hop_bounded_label_distance_query_core regression: fail");
		$finish;
	end

	// Hang guard, far above the slowest correct run.
	initial begin : watchdog
		#10_000_000;
		$display("hop_bounded_label_distance_query_core regression: fail");
		$finish;
	end

endmodule

[filelist.f]
src/hldq_pkg.sv
src/hldq_ram.sv
src/hldq_scan.sv
src/hop_bounded_label_distance_query_core.sv
src/hldq_checker.sv
test/hop_bounded_label_distance_query_core_test.sv
